[rtl/adh_pkg.sv]
// Shared types and constants for the adjacent difference histogram block.
`timescale 1ns / 1ps

package adh_pkg;

    localparam int DATA_W     = 32;
    localparam int USED_OUT_W = 7;
    localparam logic [DATA_W-1:0] COUNT_MAX = {DATA_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_APPEND,
        ST_DUMP_READ,
        ST_DUMP_OUT,
        ST_DUMP_EMPTY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] diff;
        logic [DATA_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic have_prev;
        logic last_pend;
        logic hit;
        logic more;
        logic used_zero;
        logic final_entry;
        logic out_free;
    } seq_status_t;

    typedef struct packed {
        logic ready;
        logic k_clear;
        logic search_issue;
        logic write_hit;
        logic write_append;
        logic load_entry;
        logic load_empty;
        logic clear_set;
    } seq_ctrl_t;

endpackage

[rtl/adh_ram.sv]
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps

module adh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/adh_seq.sv]
// Sequencer for table search, update and dump.
`timescale 1ns / 1ps

module adh_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  adh_pkg::seq_status_t status,
    output adh_pkg::seq_ctrl_t   ctrl
);

    import adh_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    if (status.have_prev)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else if (status.in_last)
                    begin
                        state_next = ST_DUMP_READ;
                    end
                end
            end
            ST_SEARCH:
            begin
                priority if (status.hit)
                begin
                    state_next = ST_UPDATE;
                end
                else if (!status.more)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_UPDATE, ST_APPEND:
            begin
                state_next = status.last_pend ? ST_DUMP_READ : ST_IDLE;
            end
            ST_DUMP_READ:
            begin
                state_next = status.used_zero ? ST_DUMP_EMPTY : ST_DUMP_OUT;
            end
            ST_DUMP_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = status.final_entry ? ST_FINISH : ST_DUMP_READ;
                end
            end
            ST_DUMP_EMPTY:
            begin
                if (status.out_free)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.ready   = 1'b1;
                ctrl.k_clear = 1'b1;
            end
            ST_SEARCH:
            begin
                ctrl.search_issue = !status.hit && status.more;
            end
            ST_UPDATE:
            begin
                ctrl.write_hit = 1'b1;
                ctrl.k_clear   = 1'b1;
            end
            ST_APPEND:
            begin
                ctrl.write_append = 1'b1;
                ctrl.k_clear      = 1'b1;
            end
            ST_DUMP_READ:
            begin
            end
            ST_DUMP_OUT:
            begin
                ctrl.load_entry = status.out_free;
            end
            ST_DUMP_EMPTY:
            begin
                ctrl.load_empty = status.out_free;
            end
            ST_FINISH:
            begin
                ctrl.clear_set = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

[rtl/adjacent_difference_histogram_core.sv]
// Top level of the adjacent difference histogram block.
//
// Input channel (value, last_item): in_valid / in_stall, taken when in_valid is high and
// in_stall is low. Each value after the first of a set yields an absolute difference that
// is looked up in a table of distinct differences (first-appearance order).
// Output channel (diff, count, entry_valid, entries_used, overflow, last): out_valid /
// out_stall, one transaction per table entry, issued after the item marked last_item.
// A set holding a single value gives one transaction with entry_valid low.
// The search for a difference is sequential: it reads one table entry per cycle from the
// table RAM and ends at a hit or after the last used entry. The first value of a set
// starts no search. A dump reads each entry and then loads it into the output register,
// waiting while the receiver holds out_stall, and ends by clearing the set; the block
// keeps in_stall high until the dump is finished. The last result sits in the output
// register while the next value is accepted.
// Reset clears the set state (entry count, overflow, previous-value flag) at once;
// no clearing pass over the table is needed.
`timescale 1ns / 1ps

module adjacent_difference_histogram_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [adh_pkg::DATA_W-1:0]          value,
    input  logic                                last_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [adh_pkg::DATA_W-1:0]          diff,
    output logic [adh_pkg::DATA_W-1:0]          count,
    output logic                                entry_valid,
    output logic [adh_pkg::USED_OUT_W-1:0]      entries_used,
    output logic                                overflow,
    output logic                                last
);

    import adh_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    seq_status_t status;
    seq_ctrl_t   ctrl;

    entry_t            rd_entry;
    entry_t            wr_entry;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] abs_diff;
    logic              in_fire;
    logic              hit;
    logic              more;
    logic              final_entry;
    logic              out_free;
    logic              table_full;

    // control state
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  used_reg;
    logic              overflow_reg;
    logic              have_prev_reg;
    logic              last_pend_reg;
    logic              cmp_valid_reg;
    logic              out_valid_reg;

    // payload
    logic [DATA_W-1:0] prev_reg;
    logic [DATA_W-1:0] diff_val_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [DATA_W-1:0] hit_count_reg;
    logic [DATA_W-1:0] count_next;
    entry_t            out_entry_reg;
    logic              entry_valid_reg;
    logic [USED_OUT_W-1:0] entries_used_reg;
    logic              overflow_out_reg;
    logic              last_reg;

    adh_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    adh_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    assign in_fire     = in_valid && ctrl.ready;
    assign abs_diff    = (value > prev_reg) ? (value - prev_reg) : (prev_reg - value);
    assign hit         = cmp_valid_reg && (rd_entry.diff == diff_val_reg);
    assign more        = k_reg < used_reg;
    assign final_entry = (k_reg + CNT_W'(1)) == used_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    assign table_full  = used_reg >= DEPTH_CNT;
    assign rd_addr     = k_reg[IDX_W-1:0];
    assign count_next  = (hit_count_reg == COUNT_MAX) ? hit_count_reg
                                                      : hit_count_reg + DATA_W'(1);

    always_comb
    begin
        status.in_valid    = in_valid;
        status.in_last     = last_item;
        status.have_prev   = have_prev_reg;
        status.last_pend   = last_pend_reg;
        status.hit         = hit;
        status.more        = more;
        status.used_zero   = (used_reg == '0);
        status.final_entry = final_entry;
        status.out_free    = out_free;
    end

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = cmp_idx_reg;
        wr_entry = '{diff: diff_val_reg, count: count_next};
        if (ctrl.write_hit)
        begin
            wr_en = 1'b1;
        end
        else if (ctrl.write_append && !table_full)
        begin
            wr_en    = 1'b1;
            wr_addr  = used_reg[IDX_W-1:0];
            wr_entry = '{diff: diff_val_reg, count: DATA_W'(1)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            used_reg      <= '0;
            overflow_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            last_pend_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= ctrl.search_issue;

            if (ctrl.k_clear)
            begin
                k_reg <= '0;
            end
            else if (ctrl.search_issue || ctrl.load_entry)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end

            if (in_fire)
            begin
                have_prev_reg <= 1'b1;
                last_pend_reg <= last_item;
            end

            if (ctrl.write_append)
            begin
                if (table_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    used_reg <= used_reg + CNT_W'(1);
                end
            end

            if (ctrl.clear_set)
            begin
                used_reg      <= '0;
                overflow_reg  <= 1'b0;
                have_prev_reg <= 1'b0;
                last_pend_reg <= 1'b0;
            end

            if (ctrl.load_entry || ctrl.load_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            prev_reg     <= value;
            diff_val_reg <= abs_diff;
        end

        if (ctrl.search_issue)
        begin
            cmp_idx_reg <= k_reg[IDX_W-1:0];
        end

        if (cmp_valid_reg)
        begin
            hit_count_reg <= rd_entry.count;
        end

        if (ctrl.load_entry)
        begin
            out_entry_reg    <= rd_entry;
            entry_valid_reg  <= 1'b1;
            entries_used_reg <= USED_OUT_W'(used_reg);
            overflow_out_reg <= overflow_reg;
            last_reg         <= final_entry;
        end
        else if (ctrl.load_empty)
        begin
            out_entry_reg    <= '0;
            entry_valid_reg  <= 1'b0;
            entries_used_reg <= '0;
            overflow_out_reg <= overflow_reg;
            last_reg         <= 1'b1;
        end
    end

    assign in_stall     = !ctrl.ready;
    assign out_valid    = out_valid_reg;
    assign diff         = out_entry_reg.diff;
    assign count        = out_entry_reg.count;
    assign entry_valid  = entry_valid_reg;
    assign entries_used = entries_used_reg;
    assign overflow     = overflow_out_reg;
    assign last         = last_reg;

endmodule

[rtl/adh_checker.sv]
// Port-level checks for the adjacent difference histogram block, with bind.
`timescale 1ns / 1ps

module adh_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [adh_pkg::DATA_W-1:0]     value,
    input logic                           last_item,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [adh_pkg::DATA_W-1:0]     diff,
    input logic [adh_pkg::DATA_W-1:0]     count,
    input logic                           entry_valid,
    input logic [adh_pkg::USED_OUT_W-1:0] entries_used,
    input logic                           overflow,
    input logic                           last
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(diff) && $stable(count)
            && $stable(last) && $stable(entry_valid))
        else $error("output transaction changed while stalled");

    // the empty-set marker is always the final result, with no fill and a zero count
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_valid |-> last && (entries_used == '0) && (count == '0))
        else $error("invalid entry result malformed");

    // a real entry implies a nonzero table fill with a nonzero count
    a_entry_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_valid |-> (entries_used != '0) && (count != '0))
        else $error("valid entry with empty table or zero count");

    // the closing value of a set always makes the block busy next cycle
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_item |=> in_stall)
        else $error("block ready right after last value of set");

endmodule

bind adjacent_difference_histogram_core adh_checker u_adh_checker (.*);

[tb/tb_adjacent_difference_histogram_core.sv]
// Testbench for adjacent_difference_histogram_core: directed and random sets, scoreboard checked.
`timescale 1ns / 1ps

module tb_adjacent_difference_histogram_core;

    import adh_pkg::*;

    localparam int DEPTH       = 64;
    localparam int ITEM_TARGET = 380;

    typedef struct packed {
        logic [DATA_W-1:0]     diff;
        logic [DATA_W-1:0]     count;
        logic                  entry_valid;
        logic [USED_OUT_W-1:0] entries_used;
        logic                  overflow;
        logic                  last;
    } hist_entry_t;

    // Tracks the running histogram of a set and holds the dump it should produce.
    class hist_scoreboard;
        logic [DATA_W-1:0] prev_value;
        bit                have_prev;
        logic [DATA_W-1:0] diff_tab [DEPTH];
        logic [DATA_W-1:0] count_tab [DEPTH];
        int unsigned       used;
        bit                table_full_hit;
        hist_entry_t       expected_entries[$];
        int                errors;
        int                sets_done;
        int                single_value_sets;
        int                overflow_sets;
        int                entries_checked;

        function new();
            prev_value        = '0;
            have_prev         = 0;
            used              = 0;
            table_full_hit    = 0;
            errors            = 0;
            sets_done         = 0;
            single_value_sets = 0;
            overflow_sets     = 0;
            entries_checked   = 0;
        endfunction

        function void add_difference(logic [DATA_W-1:0] d);
            int unsigned k;
            for (k = 0; k < used; k++) begin
                if (diff_tab[k] == d) begin
                    if (count_tab[k] != COUNT_MAX)
                        count_tab[k] = count_tab[k] + 1'b1;
                    return;
                end
            end
            if (used < DEPTH) begin
                diff_tab[used]  = d;
                count_tab[used] = 1;
                used++;
            end else begin
                table_full_hit = 1;
            end
        endfunction

        function void record_value(logic [DATA_W-1:0] v, logic is_last);
            hist_entry_t e;
            int unsigned k;
            if (have_prev)
                add_difference((v > prev_value) ? v - prev_value : prev_value - v);
            prev_value = v;
            have_prev  = 1;
            if (!is_last)
                return;
            if (used == 0) begin
                e.diff         = '0;
                e.count        = '0;
                e.entry_valid  = 1'b0;
                e.entries_used = '0;
                e.overflow     = table_full_hit;
                e.last         = 1'b1;
                expected_entries.push_back(e);
                single_value_sets++;
            end else begin
                for (k = 0; k < used; k++) begin
                    e.diff         = diff_tab[k];
                    e.count        = count_tab[k];
                    e.entry_valid  = 1'b1;
                    e.entries_used = used[USED_OUT_W-1:0];
                    e.overflow     = table_full_hit;
                    e.last         = (k + 1 == used);
                    expected_entries.push_back(e);
                end
            end
            if (table_full_hit)
                overflow_sets++;
            sets_done++;
            prev_value     = '0;
            have_prev      = 0;
            used           = 0;
            table_full_hit = 0;
        endfunction

        task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] exp);
            if (errors < 30)
                $display("MISMATCH @%0t entry %0d: %s got %h expected %h",
                         $realtime, entries_checked, what, got, exp);
            errors++;
        endtask

        task check_entry(hist_entry_t got);
            hist_entry_t exp;
            if (expected_entries.size() == 0) begin
                report_mismatch("unexpected transaction, diff", got.diff, '0);
                return;
            end
            exp = expected_entries.pop_front();
            if (got.diff !== exp.diff)
                report_mismatch("diff", got.diff, exp.diff);
            if (got.count !== exp.count)
                report_mismatch("count", got.count, exp.count);
            if (got.entry_valid !== exp.entry_valid)
                report_mismatch("entry_valid", DATA_W'(got.entry_valid),
                                DATA_W'(exp.entry_valid));
            if (got.entries_used !== exp.entries_used)
                report_mismatch("entries_used", DATA_W'(got.entries_used),
                                DATA_W'(exp.entries_used));
            if (got.overflow !== exp.overflow)
                report_mismatch("overflow", DATA_W'(got.overflow), DATA_W'(exp.overflow));
            if (got.last !== exp.last)
                report_mismatch("last", DATA_W'(got.last), DATA_W'(exp.last));
            entries_checked++;
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [DATA_W-1:0]     value     = '0;
    logic                  last_item = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DATA_W-1:0]     diff;
    logic [DATA_W-1:0]     count;
    logic                  entry_valid;
    logic [USED_OUT_W-1:0] entries_used;
    logic                  overflow;
    logic                  last;

    hist_scoreboard sb;
    int             items_sent = 0;
    int             burst_left = 0;
    int             stall_mode = 0;
    int             stall_span = 0;

    adjacent_difference_histogram_core #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .diff         (diff),
        .count        (count),
        .entry_valid  (entry_valid),
        .entries_used (entries_used),
        .overflow     (overflow),
        .last         (last)
    );

    always #5 clk = ~clk;

    // Receiver: stall behavior switches between random modes, each held for a random span.
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(20, 300);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        hist_entry_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.diff         = diff;
            got.count        = count;
            got.entry_valid  = entry_valid;
            got.entries_used = entries_used;
            got.overflow     = overflow;
            got.last         = last;
            sb.check_entry(got);
        end
    end

    // Holds the transaction until accepted, then maybe drops valid for a random gap.
    task automatic send_item(input logic [DATA_W-1:0] v, input logic is_last);
        int gap;
        value     <= v;
        last_item <= is_last;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.record_value(v, is_last);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // More than a table's worth of distinct differences, then repeats mixed with new ones.
    task automatic send_overflow_set();
        int                n;
        int                i;
        int unsigned       step;
        logic [DATA_W-1:0] v;
        n = $urandom_range(68, 76);
        v = 32'h8000_0000 ^ ($urandom & 32'h00FF_FFFF);
        for (i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                step = (i > DEPTH + 1 && $urandom_range(0, 1) == 0) ? $urandom_range(1, i)
                                                                     : i;
                v = ($urandom_range(0, 1) == 0) ? v + step : v - step;
            end
            send_item(v, i == n - 1);
        end
    endtask

    // Values from a few levels, so differences repeat often.
    task automatic send_clustered_set();
        int                n;
        int                i;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] spacing;
        n       = $urandom_range(1, 12);
        base    = $urandom;
        spacing = $urandom_range(1, 1000);
        for (i = 0; i < n; i++)
            send_item(base + spacing * $urandom_range(0, 7), i == n - 1);
    endtask

    task automatic send_noise_set();
        int n;
        int i;
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
            send_item($urandom, i == n - 1);
    endtask

    initial
    begin
        int kind;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single value: empty table
        send_item(32'hFFFF_FFFF, 1'b1);
        // largest difference, both directions
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);
        // zero difference
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b1);
        // repeated differences kept in order of first appearance
        send_item(32'd100, 1'b0);
        send_item(32'd90, 1'b0);
        send_item(32'd110, 1'b0);
        send_item(32'd100, 1'b0);
        send_item(32'd95, 1'b0);
        send_item(32'd105, 1'b1);
        // around the sign boundary
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h0000_0000, 1'b1);

        send_overflow_set();
        while (items_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 2)
                send_overflow_set();
            else if (kind < 12)
                send_clustered_set();
            else
                send_noise_set();
        end
        in_valid <= 1'b0;

        while (sb.expected_entries.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d sets over %0d values: %0d single-value, %0d with table overflow.",
                 sb.sets_done, items_sent, sb.single_value_sets, sb.overflow_sets);
        $display("Checked %0d histogram entries, %0d mismatches.",
                 sb.entries_checked, sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d entries still expected.", sb.expected_entries.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/adh_pkg.sv
rtl/adh_ram.sv
rtl/adh_seq.sv
rtl/adjacent_difference_histogram_core.sv
rtl/adh_checker.sv
tb/tb_adjacent_difference_histogram_core.sv
